// ----- rtl/core/bkt_pkg.sv -----
// Shared types, constants and helpers for the bucketed key table.
// Used by bkt_cell_ram, bkt_fill_ram and bucketed_key_table_top.
`timescale 1ns / 1ps

package bkt_pkg;

  // Table geometry
  localparam int BUCKETS   = 64;
  localparam int CELLS     = 8;
  localparam int KEY_BYTES = 8;

  // Field widths
  localparam int OP_W     = 2;
  localparam int BUCKET_W = 6;
  localparam int KEY_W    = 64;

  // Derived widths
  localparam int BKT_IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int CELL_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNT_W     = $clog2(CELLS + 1);

  // Operation codes
  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_FIND  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [BUCKET_W-1:0] bucket;
    logic [KEY_W-1:0]    key;
  } req_t;

  typedef struct packed {
    logic             ok;
    logic [KEY_W-1:0] entry_out;
  } rsp_t;

  // One bucket row: all cells side by side
  typedef logic [CELLS-1:0][KEY_W-1:0] row_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_t;

  // Cut the key at its first zero byte and drop bytes at or above KEY_BYTES
  function automatic logic [KEY_W-1:0] normalize_key(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] r;
    logic             run;
    r   = '0;
    run = 1'b1;
    for (int i = 0; i < KEY_W / 8; i++) begin
      if (i < KEY_BYTES && run && k[8*i +: 8] != 8'h00) begin
        r[8*i +: 8] = k[8*i +: 8];
      end else begin
        run = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/bkt_cell_ram.sv -----
// Key storage: one row per bucket, all cells of a row read together.
// Single cell written per cycle. Depends on bkt_pkg.
`timescale 1ns / 1ps

module bkt_cell_ram
  import bkt_pkg::*;
(
  input  logic                 clk,
  input  logic                 re,
  input  logic [BKT_IDX_W-1:0] raddr,
  output row_t                 rdata,
  input  logic                 we,
  input  logic [BKT_IDX_W-1:0] waddr,
  input  logic [CELL_W-1:0]    wcell,
  input  logic [KEY_W-1:0]     wdata
);

  row_t mem [BUCKETS];

  // Cell write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr][wcell] <= wdata;
    end
  end

  // Registered row read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/bkt_fill_ram.sv -----
// Fill counts per bucket, with a valid bit per bucket so reset and
// clear empty every bucket at once. Depends on bkt_pkg.
`timescale 1ns / 1ps

module bkt_fill_ram
  import bkt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clr,
  input  logic                 re,
  input  logic [BKT_IDX_W-1:0] raddr,
  output logic [CNT_W-1:0]     rdata,
  input  logic                 we,
  input  logic [BKT_IDX_W-1:0] waddr,
  input  logic [CNT_W-1:0]     wdata
);

  logic [CNT_W-1:0]   mem [BUCKETS];
  logic [BUCKETS-1:0] valid;

  // Count storage
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Valid bits: invalid entries read as zero
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= valid[raddr] ? mem[raddr] : '0;
    end
  end

endmodule

// ----- rtl/core/bucketed_key_table_top.sv -----
// Bucketed key table top level: request control, compare and result register.
// Depends on bkt_pkg, bkt_cell_ram and bkt_fill_ram.
//
// Usage:
//   Requests enter on req (op, bucket, key) with req_valid/req_stall.
//   Responses leave on rsp (ok, entry_out) with rsp_valid/rsp_stall.
//   Every request gives exactly one response, in request order.
//   Add stores the key in the bucket's next free cell (ok=0 when full),
//   find reports a hit and the stored entry, clear empties all buckets.
// Timing:
//   A request is taken in ST_IDLE; the bucket row and its fill count
//   are read from the memories on that edge, and in ST_LOOK the block compares
//   all cells of the row at once and, once the response register is free,
//   writes back and loads the response register. No new request is taken
//   until then: req_stall is high throughout ST_LOOK.
// Reset and stall:
//   rst (synchronous) empties every bucket at once and drops any pending
//   response; no warm-up pass is needed. A stalled response holds in its
//   register; one more request is taken meanwhile and waits in the
//   compare stage until the response register frees up.
`timescale 1ns / 1ps

module bucketed_key_table_top
  import bkt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  state_t state, state_next;

  logic [OP_W-1:0]      cur_op;
  logic [BUCKET_W-1:0]  cur_bucket;
  logic [KEY_W-1:0]     cur_key;

  logic                 req_take;
  logic                 finish;
  logic                 rsp_free;

  row_t                 row;
  logic [CNT_W-1:0]     cnt;
  logic [CELLS-1:0]     hit;
  logic                 in_range;
  logic                 has_room;

  logic                 res_ok;
  logic [KEY_W-1:0]     res_entry;
  logic                 cell_we;
  logic                 fill_we;
  logic                 fill_clr;

  assign req_take = req_valid && !req_stall;
  assign rsp_free = !rsp_valid || !rsp_stall;

  // State machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_stall  = 1'b1;
    finish     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (rsp_free) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (req_take) begin
      cur_op     <= req.op;
      cur_bucket <= req.bucket;
      cur_key    <= normalize_key(req.key);
    end
  end

  bkt_cell_ram u_cells (
    .clk   (clk),
    .re    (req_take),
    .raddr (req.bucket[BKT_IDX_W-1:0]),
    .rdata (row),
    .we    (cell_we),
    .waddr (cur_bucket[BKT_IDX_W-1:0]),
    .wcell (cnt[CELL_W-1:0]),
    .wdata (cur_key)
  );

  bkt_fill_ram u_fill (
    .clk   (clk),
    .rst   (rst),
    .clr   (fill_clr),
    .re    (req_take),
    .raddr (req.bucket[BKT_IDX_W-1:0]),
    .rdata (cnt),
    .we    (fill_we),
    .waddr (cur_bucket[BKT_IDX_W-1:0]),
    .wdata (cnt + CNT_W'(1))
  );

  // Compare every filled cell against the key
  always_comb begin
    for (int i = 0; i < CELLS; i++) begin
      hit[i] = (CNT_W'(i) < cnt) && (row[i] == cur_key);
    end
  end

  assign in_range = {1'b0, cur_bucket} < (BUCKET_W + 1)'(BUCKETS);
  assign has_room = cnt < CNT_W'(CELLS);

  // Result and write-back decode
  always_comb begin
    res_ok    = 1'b0;
    res_entry = '0;
    cell_we   = 1'b0;
    fill_we   = 1'b0;
    fill_clr  = 1'b0;
    if (cur_op == OP_CLEAR) begin
      res_ok   = 1'b1;
      fill_clr = finish;
    end else if (cur_op == OP_ADD && in_range) begin
      res_ok  = has_room;
      cell_we = finish && has_room;
      fill_we = finish && has_room;
    end else if (cur_op == OP_FIND && in_range) begin
      res_ok    = |hit;
      res_entry = (|hit) ? cur_key : '0;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp.ok        <= res_ok;
      rsp.entry_out <= res_entry;
    end
  end

endmodule

// ----- tb/bucketed_key_table_top_test.sv -----
// Self-checking testbench for bucketed_key_table_top: directed and random
// add/find/clear requests under random idling and stalls. Depends on bkt_pkg.
`timescale 1ns / 1ps

module bucketed_key_table_top_test;
  import bkt_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 1750;

  // Tracks table contents and the replies still owed by the block
  class key_table_checker;
    logic [KEY_W-1:0] cells [BUCKETS][CELLS];
    int unsigned fill [BUCKETS];
    rsp_t awaited_replies [$];
    int errors = 0;
    int n_stored = 0, n_full = 0, n_hit = 0, n_miss = 0, n_clear = 0, n_unused = 0;

    // Keep bytes up to the first zero byte, at most KEY_BYTES of them
    function logic [KEY_W-1:0] trim_key(logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] t;
      int i;
      t = '0;
      i = 0;
      while (i < KEY_BYTES && i < KEY_W / 8 && k[8*i +: 8] != 8'h00) begin
        t[8*i +: 8] = k[8*i +: 8];
        i++;
      end
      return t;
    endfunction

    function void note_request(req_t r);
      rsp_t want;
      logic [KEY_W-1:0] k;
      int b;
      want = '0;
      k = trim_key(r.key);
      b = r.bucket;
      case (r.op)
        OP_CLEAR: begin
          foreach (fill[i]) fill[i] = 0;
          want.ok = 1'b1;
          n_clear++;
        end
        OP_ADD: begin
          if (b < BUCKETS) begin
            if (fill[b] < CELLS) begin
              cells[b][fill[b]] = k;
              fill[b]++;
              want.ok = 1'b1;
              n_stored++;
            end else begin
              n_full++;
            end
          end
        end
        OP_FIND: begin
          if (b < BUCKETS) begin
            // first match in cell order, filled cells only
            for (int c = 0; c < fill[b]; c++) begin
              if (cells[b][c] == k) begin
                want.ok = 1'b1;
                want.entry_out = cells[b][c];
                break;
              end
            end
          end
          if (want.ok) n_hit++;
          else n_miss++;
        end
        default: n_unused++;
      endcase
      awaited_replies.push_back(want);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_reply(rsp_t got);
      rsp_t want;
      if (awaited_replies.size() == 0) begin
        report_mismatch($sformatf("reply with nothing outstanding (ok=%0b entry=%h)",
                                  got.ok, got.entry_out));
      end else begin
        want = awaited_replies.pop_front();
        if (got.ok !== want.ok)
          report_mismatch($sformatf("ok got %b want %b", got.ok, want.ok));
        if (got.entry_out !== want.entry_out)
          report_mismatch($sformatf("entry_out got %h want %h", got.entry_out,
                                    want.entry_out));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  bit calm_phase = 1'b0;
  key_table_checker sb = new;

  // Recently added keys, for finds that should hit
  int pool_bucket [$];
  logic [KEY_W-1:0] pool_key [$];
  int hot [4];

  bucketed_key_table_top DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Response side stalls at random outside the calm stretch
  always @(negedge clk) begin
    rsp_stall = calm_phase ? 1'b0 : ($urandom_range(0, 99) < 27);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) sb.check_reply(rsp);
  end

  // Randomize every byte above the terminator of the key
  function automatic logic [KEY_W-1:0] scramble_tail(logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] t;
    int n;
    t = k;
    n = 0;
    while (n < 8 && t[8*n +: 8] != 8'h00) n++;
    for (int j = n + 1; j < 8; j++) t[8*j +: 8] = 8'($urandom);
    return t;
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    int len;
    int mode;
    mode = $urandom_range(0, 2);
    k = {$urandom, $urandom};
    if (mode != 0) begin
      // short string, nonzero bytes then zero padding
      len = $urandom_range(0, 8);
      for (int j = 0; j < 8; j++) begin
        if (j >= len) k[8*j +: 8] = 8'h00;
        else if (k[8*j +: 8] == 8'h00) k[8*j +: 8] = 8'h20;
      end
      if (mode == 2) k = scramble_tail(k);
    end
    return k;
  endfunction

  task automatic issue(input logic [OP_W-1:0] op, input int b, input logic [KEY_W-1:0] k);
    req_t r;
    r.op = op;
    r.bucket = b[BUCKET_W-1:0];
    r.key = k;
    if (!calm_phase && $urandom_range(0, 99) < 27) begin
      @(negedge clk);
      req_valid = 1'b0;
      repeat ($urandom_range(0, 2)) @(negedge clk);
    end
    @(negedge clk);
    req_valid = 1'b1;
    req = r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(r);
    if (op == OP_ADD) begin
      pool_bucket.push_back(b);
      pool_key.push_back(k);
      if (pool_key.size() > 32) begin
        void'(pool_bucket.pop_front());
        void'(pool_key.pop_front());
      end
    end
  endtask

  task automatic wait_all_replies();
    @(negedge clk);
    req_valid = 1'b0;
    while (sb.awaited_replies.size() != 0) @(posedge clk);
  endtask

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int roll;
    int pick;
    int guard;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: fill bucket 0 to overflow, odd keys, last bucket, unused op
    issue(OP_CLEAR, 0, '0);
    issue(OP_ADD, 0, 64'h41);
    issue(OP_ADD, 0, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(OP_ADD, 0, 64'h0);
    issue(OP_ADD, 0, 64'hDEAD_BEEF_0000_4241);   // garbage after terminator
    issue(OP_ADD, 0, 64'h0102_0304_0506_0708);
    issue(OP_ADD, 0, 64'h80);
    issue(OP_ADD, 0, 64'h7F7F_7F7F_7F7F_7F7F);
    issue(OP_ADD, 0, 64'h5555_5555_5555_5555);
    issue(OP_ADD, 0, 64'h43);                    // bucket full
    issue(OP_FIND, 0, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(OP_FIND, 0, 64'h1234_0000_0000_4241);  // same string, other tail
    issue(OP_FIND, 0, 64'h0);                    // empty string
    issue(OP_FIND, 0, 64'h43);
    issue(OP_FIND, 63, 64'h41);
    issue(OP_ADD, 63, 64'hAAAA_AAAA_AAAA_AAAA);
    issue(OP_FIND, 63, 64'hAAAA_AAAA_AAAA_AAAA);
    issue(OP_FIND, 63, 64'h5555_5555_5555_5555);
    issue(OP_UNUSED, 0, 64'h41);
    issue(OP_CLEAR, 63, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(OP_FIND, 0, 64'h41);                   // stale cell after clear
    issue(OP_ADD, 0, 64'h99);
    issue(OP_FIND, 0, 64'h99);
    wait_all_replies();

    // Random: mostly adds and finds on a few hot buckets
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      calm_phase = (i >= 700 && i < 1000);
      if (i % 150 == 0) foreach (hot[h]) hot[h] = $urandom_range(0, BUCKETS - 1);
      if (i % 450 == 449) wait_all_replies();
      roll = $urandom_range(0, 199);
      if (roll < 3) begin
        issue(OP_CLEAR, $urandom_range(0, 63), fresh_key());
      end else if (roll < 8) begin
        issue(OP_UNUSED, $urandom_range(0, 63), fresh_key());
      end else if (roll < 96) begin
        issue(OP_ADD, ($urandom_range(0, 9) < 7) ? hot[$urandom_range(0, 3)]
                                                : $urandom_range(0, 63), fresh_key());
      end else if (pool_key.size() != 0 && $urandom_range(0, 99) < 65) begin
        pick = $urandom_range(0, pool_key.size() - 1);
        issue(OP_FIND, pool_bucket[pick],
              $urandom_range(0, 1) ? scramble_tail(pool_key[pick]) : pool_key[pick]);
      end else begin
        issue(OP_FIND, ($urandom_range(0, 9) < 7) ? hot[$urandom_range(0, 3)]
                                                 : $urandom_range(0, 63), fresh_key());
      end
    end

    // Drain outstanding replies, then let the pipeline settle
    @(negedge clk);
    req_valid = 1'b0;
    guard = 0;
    while (sb.awaited_replies.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (sb.awaited_replies.size() != 0)
      sb.report_mismatch($sformatf("%0d replies never arrived", sb.awaited_replies.size()));

    $display("run covered %0d stored adds, %0d adds to full buckets, %0d find hits, %0d misses",
             sb.n_stored, sb.n_full, sb.n_hit, sb.n_miss);
    $display("plus %0d clears and %0d unused-op requests; %0d mismatches",
             sb.n_clear, sb.n_unused, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
